@@ src/tks_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tks_pkg;

  // Chain depth and row length.
  localparam int K_MAX         = 16;
  localparam int ROW_ITEMS_MAX = 65536;

  // Derived widths.
  localparam int IDX_W     = (ROW_ITEMS_MAX > 1) ? $clog2(ROW_ITEMS_MAX) : 1;
  localparam int CNT_W     = $clog2(K_MAX + 1);
  localparam int KI_W      = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int SCORE_W   = 32;
  localparam int OUT_IDX_W = 16;
  localparam int KREG_W    = 5;
  localparam int KC_W      = (CNT_W > KREG_W) ? CNT_W : KREG_W;

  // Register map.
  localparam int APB_ADDR_W = 3;
  localparam logic [APB_ADDR_W-1:0] RegKUsedAddr = 3'd0;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [IDX_W-1:0]          index;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic shift_up;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  // Order by score, then by index.
  function automatic logic entry_gt(entry_t a, entry_t b);
    logic gt_score;
    logic eq_score;
    gt_score = $signed(a.score) > $signed(b.score);
    eq_score = a.score == b.score;
    return gt_score || (eq_score && (a.index > b.index));
  endfunction

endpackage

`default_nettype wire

@@ src/tks_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tks_cell (
  input  wire logic               clk_i,
  input  wire tks_pkg::cell_ctrl_t ctrl_i,
  input  wire logic               valid_i,
  input  wire tks_pkg::entry_t    new_i,
  input  wire tks_pkg::entry_t    prev_i,
  input  wire logic               prev_take_i,
  input  wire tks_pkg::entry_t    next_i,
  output tks_pkg::entry_t         entry_o,
  output logic                    take_o
);
  import tks_pkg::*;

  entry_t entry_q, entry_d;

  // An empty cell ranks below everything.
  assign take_o  = !valid_i || entry_gt(new_i, entry_q);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift_up) begin
      entry_d = next_i;
    end else if (ctrl_i.insert && take_o) begin
      // Upper neighbor also moved down: take its entry, else land the new one.
      entry_d = prev_take_i ? prev_i : new_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

@@ src/streaming_top_k_select_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Streaming top-k selector. Scores enter on the slave stream, one per request,
// and are numbered from 0 within a row; the index saturates at the last value
// of the row range. A row of K_MAX cells keeps the entries sorted, highest
// score first, equal scores larger index first. While fewer than k_used
// entries are kept, every score is inserted; afterwards a score displaces the
// lowest kept entry only when it is strictly greater. Each accepted score is
// inserted by a single parallel compare-and-shift along the chain. On the
// request flagged tlast the block stops accepting and streams min(filled, k)
// results, k being k_used clamped to [1, K_MAX], one per cycle while m_tready
// is high, by shifting the chain toward cell 0; input is taken again in the
// cycle after the last result. k_used is written at byte address 0 over the
// APB port; the user must write it only while the block is idle, which the
// block itself does not enforce. Only pwdata[4:0] is kept; 0 acts as 1,
// stored values above K_MAX as K_MAX.
module streaming_top_k_select_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // APB configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [tks_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready,
  // Input stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [31:0]                       s_tdata,  // [31:0] score
  input  wire logic                              s_tlast,  // last_in_row
  // Result stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [47:0]                       m_tdata,  // [15:0] item_index,
                                                           // [47:16] item_score
  output logic                                   m_tlast   // last_result
);
  import tks_pkg::*;

  state_e              state_q, state_d;
  logic [KREG_W-1:0]   k_used_q;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [CNT_W-1:0]    remain_q, remain_d;
  logic [IDX_W-1:0]    row_pos_q, row_pos_d;

  // Configuration port.
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == RegKUsedAddr);
  assign prdata = (paddr == RegKUsedAddr) ? 32'(k_used_q) : 32'd0;

  // Effective k, clamped to [1, K_MAX].
  logic [KC_W-1:0] k_eff;
  always_comb begin
    if (k_used_q == '0) begin
      k_eff = KC_W'(1);
    end else if (KC_W'(k_used_q) > KC_W'(K_MAX)) begin
      k_eff = KC_W'(K_MAX);
    end else begin
      k_eff = KC_W'(k_used_q);
    end
  end

  // Handshakes.
  logic in_req, out_req;
  assign s_tready = (state_q == ST_IDLE);
  assign m_tvalid = (state_q == ST_DRAIN);
  assign in_req   = s_tvalid && s_tready;
  assign out_req  = m_tvalid && m_tready;

  entry_t new_entry;
  assign new_entry.score = $signed(s_tdata[SCORE_W-1:0]);
  assign new_entry.index = row_pos_q;

  // Chain of cells.
  entry_t           cell_entry [K_MAX];
  logic [K_MAX-1:0] cell_take;
  logic [K_MAX-1:0] cell_valid;
  cell_ctrl_t       ctrl;

  // Lowest kept entry sits at the tail of the filled part.
  logic [KI_W-1:0] tail_idx;
  entry_t          tail_entry;
  logic            full, insert_go;
  assign tail_idx   = KI_W'(fill_q - CNT_W'(1));
  assign tail_entry = cell_entry[tail_idx];
  assign full       = KC_W'(fill_q) >= k_eff;
  assign insert_go  = !full || ($signed(s_tdata[SCORE_W-1:0]) > $signed(tail_entry.score));

  assign ctrl.insert   = in_req && insert_go;
  assign ctrl.shift_up = out_req;

  for (genvar g = 0; g < K_MAX; g++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_t;
    assign cell_valid[g] = CNT_W'(g) < fill_q;
    if (g == 0) begin : g_head
      assign prev_e = new_entry;
      assign prev_t = 1'b0;
    end else begin : g_body
      assign prev_e = cell_entry[g-1];
      assign prev_t = cell_take[g-1];
    end
    if (g == K_MAX - 1) begin : g_tail
      assign next_e = new_entry;
    end else begin : g_inner
      assign next_e = cell_entry[g+1];
    end
    tks_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .valid_i     (cell_valid[g]),
      .new_i       (new_entry),
      .prev_i      (prev_e),
      .prev_take_i (prev_t),
      .next_i      (next_e),
      .entry_o     (cell_entry[g]),
      .take_o      (cell_take[g])
    );
  end

  // Grow while not full; a displacement keeps the count.
  logic [CNT_W-1:0] fill_grow;
  assign fill_grow = full ? fill_q : fill_q + CNT_W'(1);

  // Number of results once the closing item is in.
  logic [CNT_W-1:0] emit;
  assign emit = (KC_W'(fill_grow) > k_eff) ? CNT_W'(k_eff) : fill_grow;

  // Row control.
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    remain_d  = remain_q;
    row_pos_d = row_pos_q;
    case (state_q)
      ST_IDLE: begin
        if (in_req) begin
          fill_d = fill_grow;
          if (row_pos_q != IDX_W'(ROW_ITEMS_MAX - 1)) begin
            row_pos_d = row_pos_q + IDX_W'(1);
          end
          if (s_tlast) begin
            remain_d = emit;
            state_d  = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_req) begin
          remain_d = remain_q - CNT_W'(1);
          if (remain_q == CNT_W'(1)) begin
            // Clear the row and accept again.
            fill_d    = '0;
            row_pos_d = '0;
            state_d   = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      k_used_q  <= KREG_W'(1);
      fill_q    <= '0;
      remain_q  <= '0;
      row_pos_q <= '0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      remain_q  <= remain_d;
      row_pos_q <= row_pos_d;
      if (cfg_wr) begin
        k_used_q <= pwdata[KREG_W-1:0];
      end
    end
  end

  // Results come straight off the head cell.
  assign m_tdata = {cell_entry[0].score, OUT_IDX_W'(cell_entry[0].index)};
  assign m_tlast = (remain_q == CNT_W'(1));

  // Never take input and present results at once.
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_tready && m_tvalid))
    else $error("input and output active together");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(K_MAX))
    else $error("fill count beyond chain depth");

  a_row_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_req && m_tlast) |=> (fill_q == '0) && (row_pos_q == '0) && s_tready)
    else $error("row state not cleared after report");

  a_drain_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_req && s_tlast) |=> m_tvalid && (remain_q != '0))
    else $error("closing item did not start a report");

  a_chain_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tready && (fill_q >= CNT_W'(2))) |-> !entry_gt(cell_entry[1], cell_entry[0]))
    else $error("head cells out of order");

endmodule

`default_nettype wire
